[rtl/ted_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_pkg
// Codes, byte-class constants and helpers for the text encoding detector.
// ----------------------------------------------------------------------------
package ted_pkg;

    // verdict codes on the result channel
    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_UTF16LE = 3'd1;
    localparam logic [2:0] ENC_UTF16BE = 3'd2;
    localparam logic [2:0] ENC_GBK     = 3'd3;
    localparam logic [2:0] ENC_GB18030 = 3'd4;

    // byte-order mark found at the head of the file
    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_UTF8 = 2'd1,
        MARK_LE   = 2'd2,
        MARK_BE   = 2'd3
    } t_mark;

    localparam logic [15:0] SCAN_LIMIT_RST = 16'd8192;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;
    localparam logic [15:0] HEAD_LE        = 16'hFFFE;
    localparam logic [15:0] HEAD_BE        = 16'hFEFF;
    localparam logic [15:0] HEAD_UTF8      = 16'hEFBB;
    localparam logic [7:0]  UTF8_MARK_END  = 8'hBF;

    localparam logic [7:0] GBK_LEAD_LO  = 8'h81;
    localparam logic [7:0] GBK_LEAD_HI  = 8'hFE;
    localparam logic [7:0] GBK_TRAIL_LO = 8'h40;
    localparam logic [7:0] GBK_TRAIL_HI = 8'h7E;
    localparam logic [7:0] GBK_HIGH_LO  = 8'h80;

    // ten times the pair count is kept alongside the count
    localparam int unsigned GBK_X10_W = 20;
    localparam logic [GBK_X10_W-1:0] GBK_STEP = GBK_X10_W'(10);

    function automatic logic is_gbk_lead(input logic [7:0] b);
        is_gbk_lead = (b >= GBK_LEAD_LO) && (b <= GBK_LEAD_HI);
    endfunction

    function automatic logic is_gbk_trail(input logic [7:0] b);
        is_gbk_trail = ((b >= GBK_TRAIL_LO) && (b <= GBK_TRAIL_HI)) ||
                       ((b >= GBK_HIGH_LO) && (b <= GBK_LEAD_HI));
    endfunction

endpackage

[rtl/text_encoding_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector_unit
// Byte-stream charset detector: BOM check, UTF-8 structure, GBK pair density.
// ----------------------------------------------------------------------------
// The block takes one byte of a file per item and returns a single verdict
// (0 UTF-8, 1 UTF-16LE, 2 UTF-16BE, 3 GBK, 4 GB18030) on the item marked
// is_last, after which it is ready for the next file. An item with has_byte
// low and is_last high ends an empty file. One item is accepted per clock
// unless a last item is held; an item is registered in the input register,
// then folded into the running statistics, and a last item's verdict is
// registered in the result register that drives o_out_valid. That register
// holds the verdict while i_out_stall is high; bytes that give no verdict
// keep flowing regardless, and only a second last item waits for it to
// drain. scan_limit resets to 8192; the user must write it through
// i_scan_limit_we only while no file is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module text_encoding_detector_unit
    import ted_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_scan_limit_we,
    input  logic [15:0] i_scan_limit,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_encoding
);

    // configuration
    logic [15:0] r_scan_limit;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_has;
    logic        r_in_last;

    // stream statistics
    logic [15:0]          r_bytes_seen,   n_bytes_seen;
    logic [15:0]          r_head,         n_head;
    t_mark                r_mark,         n_mark;
    logic                 r_high_seen,    n_high_seen;
    logic                 r_cont_seen,    n_cont_seen;
    logic                 r_utf8_ok,      n_utf8_ok;
    logic [1:0]           r_pending,      n_pending;
    logic [7:0]           r_prev_byte,    n_prev_byte;
    logic                 r_prev_unpaired, n_prev_unpaired;
    logic [15:0]          r_gbk_cnt,      n_gbk_cnt;
    logic [GBK_X10_W-1:0] r_gbk_x10,      n_gbk_x10;

    // result register
    logic        r_out_vld;
    logic [2:0]  r_encoding;

    logic        w_in_acc;
    logic        w_adv;
    logic        w_in_win;
    logic        w_cont;
    logic [15:0] w_window;
    logic [2:0]  w_verdict;

    // A byte item never waits; a last item waits for a free result register.
    assign w_adv      = r_in_vld && (!r_in_last || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_encoding  = r_encoding;

    // ---- per-byte update ----
    always_comb begin
        n_bytes_seen    = r_bytes_seen;
        n_head          = r_head;
        n_mark          = r_mark;
        n_high_seen     = r_high_seen;
        n_cont_seen     = r_cont_seen;
        n_utf8_ok       = r_utf8_ok;
        n_pending       = r_pending;
        n_prev_byte     = r_prev_byte;
        n_prev_unpaired = r_prev_unpaired;
        n_gbk_cnt       = r_gbk_cnt;
        n_gbk_x10       = r_gbk_x10;

        w_in_win = (r_bytes_seen < r_scan_limit);
        w_cont   = (r_in_byte[7:6] == 2'b10);

        if (r_in_has) begin
            // byte-order mark from the first three bytes
            priority if (r_bytes_seen == 16'd0) begin
                n_head = {8'h00, r_in_byte};
            end else if (r_bytes_seen == 16'd1) begin
                n_head = {r_head[7:0], r_in_byte};
                if ({r_head[7:0], r_in_byte} == HEAD_LE) begin
                    n_mark = MARK_LE;
                end else if ({r_head[7:0], r_in_byte} == HEAD_BE) begin
                    n_mark = MARK_BE;
                end
            end else if (r_bytes_seen == 16'd2) begin
                if (r_head == HEAD_UTF8 && r_in_byte == UTF8_MARK_END) begin
                    n_mark = MARK_UTF8;
                end
            end else begin
            end

            if (w_in_win) begin
                if (r_in_byte[7]) begin
                    n_high_seen = 1'b1;
                end
                if (w_cont) begin
                    n_cont_seen = 1'b1;
                end

                // UTF-8 lead / continuation structure
                if (r_utf8_ok) begin
                    priority if (r_pending != 2'd0) begin
                        if (w_cont) begin
                            n_pending = r_pending - 2'd1;
                        end else begin
                            n_utf8_ok = 1'b0;
                        end
                    end else if (!r_in_byte[7]) begin
                    end else if (r_in_byte[7:5] == 3'b110) begin
                        n_pending = 2'd1;
                    end else if (r_in_byte[7:4] == 4'b1110) begin
                        n_pending = 2'd2;
                    end else if (r_in_byte[7:3] == 5'b11110) begin
                        n_pending = 2'd3;
                    end else begin
                        n_utf8_ok = 1'b0;
                    end
                end

                // non-overlapping GBK pairs
                if (r_prev_unpaired && is_gbk_lead(r_prev_byte) &&
                    is_gbk_trail(r_in_byte)) begin
                    if (r_gbk_cnt != CNT_MAX) begin
                        n_gbk_cnt = r_gbk_cnt + 16'd1;
                        n_gbk_x10 = r_gbk_x10 + GBK_STEP;
                    end
                    n_prev_unpaired = 1'b0;
                end else begin
                    n_prev_byte     = r_in_byte;
                    n_prev_unpaired = 1'b1;
                end
            end

            if (r_bytes_seen != CNT_MAX) begin
                n_bytes_seen = r_bytes_seen + 16'd1;
            end
        end
    end

    // ---- verdict from the updated statistics ----
    always_comb begin
        w_window = (n_bytes_seen < r_scan_limit) ? n_bytes_seen : r_scan_limit;
        priority if (n_bytes_seen == 16'd0) begin
            w_verdict = ENC_UTF8;
        end else if (n_mark == MARK_UTF8) begin
            w_verdict = ENC_UTF8;
        end else if (n_mark == MARK_LE) begin
            w_verdict = ENC_UTF16LE;
        end else if (n_mark == MARK_BE) begin
            w_verdict = ENC_UTF16BE;
        end else if (!n_high_seen) begin
            w_verdict = ENC_UTF8;
        end else if (n_utf8_ok && n_pending == 2'd0 && n_cont_seen) begin
            w_verdict = ENC_UTF8;
        end else if (n_gbk_x10 > GBK_X10_W'(w_window)) begin
            w_verdict = ENC_GBK;
        end else begin
            w_verdict = ENC_GB18030;
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= SCAN_LIMIT_RST;
        end else if (i_scan_limit_we) begin
            r_scan_limit <= i_scan_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_data_byte;
            r_in_has  <= i_has_byte;
            r_in_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && r_in_last)) begin
            // end of file clears the stream for the next one
            r_bytes_seen    <= '0;
            r_head          <= '0;
            r_mark          <= MARK_NONE;
            r_high_seen     <= 1'b0;
            r_cont_seen     <= 1'b0;
            r_utf8_ok       <= 1'b1;
            r_pending       <= '0;
            r_prev_byte     <= '0;
            r_prev_unpaired <= 1'b0;
            r_gbk_cnt       <= '0;
            r_gbk_x10       <= '0;
        end else if (w_adv) begin
            r_bytes_seen    <= n_bytes_seen;
            r_head          <= n_head;
            r_mark          <= n_mark;
            r_high_seen     <= n_high_seen;
            r_cont_seen     <= n_cont_seen;
            r_utf8_ok       <= n_utf8_ok;
            r_pending       <= n_pending;
            r_prev_byte     <= n_prev_byte;
            r_prev_unpaired <= n_prev_unpaired;
            r_gbk_cnt       <= n_gbk_cnt;
            r_gbk_x10       <= n_gbk_x10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_encoding <= w_verdict;
        end
    end

`ifndef SYNTHESIS
    // stall only ever comes from a held last item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_in_last && r_out_vld))
        else $error("input stalled without a pending verdict");

    // the pair counter and its tenfold copy stay in step
    a_gbk_x10: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gbk_x10 == (GBK_X10_W'(r_gbk_cnt) << 3) + (GBK_X10_W'(r_gbk_cnt) << 1))
        else $error("GBK tenfold count out of step");

    // a verdict leaves a clean stream behind it
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=>
            (r_bytes_seen == 16'd0 && r_utf8_ok && !r_prev_unpaired && r_out_vld))
        else $error("stream not cleared after verdict");

    // result code is one of the five verdicts
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_encoding == ENC_UTF8 || o_encoding == ENC_UTF16LE ||
                         o_encoding == ENC_UTF16BE || o_encoding == ENC_GBK ||
                         o_encoding == ENC_GB18030))
        else $error("verdict code out of range");
`endif

endmodule
